// ----- rtl/mmrs_pkg.sv -----
// Shared types and constants for the row-streamed matrix multiplier.
// Used by the front decoder, the request queue, the back sequencer and the top level.
package mmrs_pkg;

   localparam int MATRIX_SIZE_DEF = 8;
   localparam int ROW_W           = 6;
   localparam int ELEM_W          = 16;
   localparam int PROD_W          = 2 * ELEM_W;
   localparam int SUM_W           = 40;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_STREAM = 1'b1;

   typedef enum logic {
      KIND_LOAD,
      KIND_STREAM
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic                      last;
      logic [ROW_W-1:0]          row;
      logic [ROW_W-1:0]          col;
      logic signed [ELEM_W-1:0]  value;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_ADD
   } back_state_type;

endpackage

// ----- rtl/mmrs_front.sv -----
// Front end: decodes each request, drops out-of-range ones, builds queue entries.
// Depends on mmrs_pkg.
module mmrs_front
   import mmrs_pkg::*;
#(
   parameter int MATRIX_SIZE = MATRIX_SIZE_DEF
) (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_operation,
   input  logic [ROW_W-1:0]          req_row_index,
   input  logic [ROW_W-1:0]          req_col_index,
   input  logic signed [ELEM_W-1:0]  req_element_value,
   input  queue_status_type          queue_status,
   output logic                      push,
   output queue_entry_type           push_entry
);

   localparam int CMP_W = ROW_W + 1;

   logic row_ok;
   logic col_ok;
   logic keep;

   assign row_ok    = CMP_W'(req_row_index) < CMP_W'(MATRIX_SIZE);
   assign col_ok    = CMP_W'(req_col_index) < CMP_W'(MATRIX_SIZE);
   assign keep      = (req_operation == OP_STREAM) ? row_ok : (row_ok && col_ok);
   assign req_ready = !queue_status.full;
   assign push      = req_valid && req_ready && keep;

   always_comb begin
      push_entry.kind  = (req_operation == OP_STREAM) ? KIND_STREAM : KIND_LOAD;
      push_entry.last  = (req_row_index == ROW_W'(MATRIX_SIZE - 1));
      push_entry.row   = req_row_index;
      push_entry.col   = req_col_index;
      push_entry.value = req_element_value;
   end

endmodule

// ----- rtl/mmrs_queue.sv -----
// Short request queue between the front decoder and the back sequencer.
// Depends on mmrs_pkg.
module mmrs_queue
   import mmrs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  queue_entry_type  push_entry,
   input  logic             pop,
   output queue_entry_type  head,
   output queue_status_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign status.full  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/mmrs_back.sv -----
// Back end: holds the B store and row accumulators, runs one multiply-accumulate
// per column and drives the result register. Depends on mmrs_pkg.
module mmrs_back
   import mmrs_pkg::*;
#(
   parameter int MATRIX_SIZE = MATRIX_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  queue_entry_type           head,
   input  queue_status_type          queue_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [ROW_W-1:0]          rsp_result_column,
   output logic signed [SUM_W-1:0]   rsp_product_value,
   output logic                      rsp_row_done
);

   localparam int DEPTH  = MATRIX_SIZE * MATRIX_SIZE;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COL_W  = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
   localparam logic [ADDR_W-1:0] SIZE_A = ADDR_W'(MATRIX_SIZE);

   back_state_type               state_ff, state_in;
   logic [COL_W-1:0]             col_ff, col_in;
   logic [ADDR_W-1:0]            base_ff, base_in;
   logic signed [ELEM_W-1:0]     value_ff, value_in;
   logic                         last_ff, last_in;

   logic signed [ELEM_W-1:0]     b_mem [DEPTH];
   logic signed [ELEM_W-1:0]     b_rd_ff;
   logic signed [SUM_W-1:0]      acc_mem [MATRIX_SIZE];
   logic signed [SUM_W-1:0]      acc_rd_ff;
   logic                         acc_rd_vld_ff;
   logic [MATRIX_SIZE-1:0]       acc_vld_ff;
   logic signed [PROD_W-1:0]     prod_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]             rsp_col_ff;
   logic signed [SUM_W-1:0]      rsp_val_ff;
   logic                         rsp_done_ff;

   logic [ADDR_W-1:0]            head_base;
   logic [ADDR_W-1:0]            head_addr;
   logic [ADDR_W-1:0]            rd_addr;
   logic signed [SUM_W-1:0]      sum;
   logic                         out_free;
   logic                         col_last;
   logic                         b_we, rd_en, mul_en, acc_we, acc_clr, out_load;

   assign head_base = ADDR_W'(head.row) * SIZE_A;
   assign head_addr = head_base + ADDR_W'(head.col);
   assign rd_addr   = base_ff + ADDR_W'(col_ff);
   assign sum       = (acc_rd_vld_ff ? acc_rd_ff : '0) + SUM_W'(prod_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign col_last  = (col_ff == COL_W'(MATRIX_SIZE - 1));

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      base_in  = base_ff;
      value_in = value_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      b_we     = 1'b0;
      rd_en    = 1'b0;
      mul_en   = 1'b0;
      acc_we   = 1'b0;
      acc_clr  = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               pop = 1'b1;
               if (head.kind == KIND_LOAD) begin
                  b_we = 1'b1;
               end else begin
                  col_in   = '0;
                  base_in  = head_base;
                  value_in = head.value;
                  last_in  = head.last;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            mul_en   = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (!last_ff || out_free) begin
               if (last_ff) begin
                  out_load = 1'b1;
                  acc_clr  = 1'b1;
               end else begin
                  acc_we = 1'b1;
               end
               if (col_last) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + COL_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (acc_we) begin
            acc_vld_ff[col_ff] <= 1'b1;
         end else if (acc_clr) begin
            acc_vld_ff[col_ff] <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      base_ff  <= base_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      if (mul_en) begin
         prod_ff <= value_ff * b_rd_ff;
      end
      if (out_load) begin
         rsp_col_ff  <= ROW_W'(col_ff);
         rsp_val_ff  <= sum;
         rsp_done_ff <= col_last;
      end
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem[head_addr] <= head.value;
      end
      if (rd_en) begin
         b_rd_ff <= b_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[col_ff] <= sum;
      end
      if (rd_en) begin
         acc_rd_ff     <= acc_mem[col_ff];
         acc_rd_vld_ff <= acc_vld_ff[col_ff];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_column = rsp_col_ff;
   assign rsp_product_value = rsp_val_ff;
   assign rsp_row_done      = rsp_done_ff;

endmodule

// ----- rtl/matrix_multiply_row_stream_core.sv -----
// Top level of the row-streamed matrix multiplier, C = A x B.
// Instantiates mmrs_front, mmrs_queue and mmrs_back; depends on mmrs_pkg.
//
//   channel | ports                                               | dir
//   req     | valid ready operation row_index col_index element_value | in
//   rsp     | valid ready result_column product_value row_done     | out
//
// A B load is written to the store straight from the idle state; an A element
// steps through store read, multiply and accumulate for each column in turn,
// in the single shared multiply-accumulate loop.
// Reset clears the queue, the sequencer and the accumulator valid bits; the B
// store is not cleared. A full result register stalls the accumulate step on
// the last element of a row; requests keep entering while the queue has room.
module matrix_multiply_row_stream_core
   import mmrs_pkg::*;
#(
   parameter int MATRIX_SIZE = MATRIX_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_operation,
   input  logic [ROW_W-1:0]          req_row_index,
   input  logic [ROW_W-1:0]          req_col_index,
   input  logic signed [ELEM_W-1:0]  req_element_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [ROW_W-1:0]          rsp_result_column,
   output logic signed [SUM_W-1:0]   rsp_product_value,
   output logic                      rsp_row_done
);

   queue_status_type  queue_status;
   queue_entry_type   push_entry;
   queue_entry_type   head;
   logic              push;
   logic              pop;

   mmrs_front #(
      .MATRIX_SIZE(MATRIX_SIZE)
   ) u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .queue_status      (queue_status),
      .push              (push),
      .push_entry        (push_entry)
   );

   mmrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   mmrs_back #(
      .MATRIX_SIZE(MATRIX_SIZE)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .queue_status      (queue_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_column (rsp_result_column),
      .rsp_product_value (rsp_product_value),
      .rsp_row_done      (rsp_row_done)
   );

`ifndef SYNTHESIS
   a_done_on_last_column: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_row_done) |-> (rsp_result_column == ROW_W'(MATRIX_SIZE - 1)))
      else $error("row_done on a column other than the last");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_status.full)
      else $error("queue overflow");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("queue underflow");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for matrix_multiply_row_stream_core (C = A x B, row-streamed).
// A table of directed requests comes first, then random bursts checked against a predictor.
// Depends on mmrs_pkg and the core RTL only.
module tb;
   import mmrs_pkg::*;

   localparam int N           = MATRIX_SIZE_DEF;
   localparam int ROW_LATENCY = 3 * N + 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_COUNT  = 400;
   localparam int N_DIRECTED  = 25;

   typedef struct packed {
      logic [ROW_W-1:0]         col;
      logic signed [SUM_W-1:0]  value;
      logic                     done;
   } c_elem_type;

   typedef struct packed {
      bit                       typed;
      logic signed [SUM_W-1:0]  c_value;
   } row_tag_type;

   typedef struct packed {
      logic                     op;
      logic [ROW_W-1:0]         row;
      logic [ROW_W-1:0]         col;
      logic signed [ELEM_W-1:0] value;
      bit                       typed;
      logic signed [SUM_W-1:0]  c_value;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_operation = OP_LOAD;
   logic [ROW_W-1:0]          req_row_index = '0;
   logic [ROW_W-1:0]          req_col_index = '0;
   logic signed [ELEM_W-1:0]  req_element_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [ROW_W-1:0]          rsp_result_column;
   logic signed [SUM_W-1:0]   rsp_product_value;
   logic                      rsp_row_done;

   logic signed [ELEM_W-1:0]  b_image [N*N];
   logic signed [SUM_W-1:0]   row_sums [N];
   c_elem_type                c_expected [$];
   row_tag_type               row_tags [$];
   int                        failures = 0;
   int                        cycle_count = 0;
   int                        burst_left = 0;
   bit                        draining = 1'b0;
   int                        stall_mode = 0;
   int                        stall_left = 0;

   stim_row_type directed_table [N_DIRECTED] = '{
      '{OP_LOAD,   6'd7,  6'd0,  16'sh7fff, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd7,  6'd1,  16'sh7fff, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd7,  6'd2,  16'sh7fff, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd7,  6'd3,  16'sh7fff, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd7,  6'd4,  16'sh7fff, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd7,  6'd5,  16'sh7fff, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd7,  6'd6,  16'sh7fff, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd7,  6'd7,  16'sh7fff, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd8,  6'd0,  16'sh1234, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd0,  6'd63, 16'sh5555, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd63, 6'd63, 16'shaaaa, 1'b0, 40'sd0},
      '{OP_STREAM, 6'd8,  6'd0,  16'sh7fff, 1'b0, 40'sd0},
      '{OP_STREAM, 6'd63, 6'd63, 16'sh8000, 1'b0, 40'sd0},
      '{OP_STREAM, 6'd7,  6'd0,  16'sh8000, 1'b1, -40'sd1073709056},
      '{OP_STREAM, 6'd7,  6'd63, 16'sh7fff, 1'b1, 40'sd1073676289},
      '{OP_LOAD,   6'd0,  6'd0,  16'sh8000, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd0,  6'd1,  16'sh8000, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd0,  6'd2,  16'sh8000, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd0,  6'd3,  16'sh8000, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd0,  6'd4,  16'sh8000, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd0,  6'd5,  16'sh8000, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd0,  6'd6,  16'sh8000, 1'b0, 40'sd0},
      '{OP_LOAD,   6'd0,  6'd7,  16'sh8000, 1'b0, 40'sd0},
      '{OP_STREAM, 6'd0,  6'd0,  16'sh8000, 1'b0, 40'sd0},
      '{OP_STREAM, 6'd7,  6'd0,  16'sh0000, 1'b1, 40'sd1073741824}
   };

   matrix_multiply_row_stream_core #(
      .MATRIX_SIZE (N)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_column (rsp_result_column),
      .rsp_product_value (rsp_product_value),
      .rsp_row_done      (rsp_row_done)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (draining) begin
         rsp_ready <= 1'b1;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(5, 40) : $urandom_range(10, 200);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= ($urandom_range(0, 4) == 0);
            default: rsp_ready <= 1'b0;
         endcase
      end
   end

   task automatic accumulate_request(input logic op, input logic [ROW_W-1:0] row,
                                     input logic [ROW_W-1:0] col,
                                     input logic signed [ELEM_W-1:0] value,
                                     input row_tag_type tag);
      logic signed [SUM_W-1:0] prod;
      c_elem_type              elem;
      int                      j;
      if (op == OP_LOAD) begin
         if (row < N && col < N)
            b_image[row * N + col] = value;
      end else if (row < N) begin
         for (j = 0; j < N; j++) begin
            prod = value * b_image[row * N + j];
            row_sums[j] = row_sums[j] + prod;
         end
         if (row == N - 1) begin
            for (j = 0; j < N; j++) begin
               elem.col   = ROW_W'(j);
               elem.value = tag.typed ? tag.c_value : row_sums[j];
               elem.done  = (j == N - 1);
               c_expected.push_back(elem);
               row_sums[j] = '0;
            end
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      c_elem_type  want;
      row_tag_type tag;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (c_expected.size() == 0) begin
               $error("unexpected result: column %0d value %0d", rsp_result_column,
                      rsp_product_value);
               failures++;
            end else begin
               want = c_expected.pop_front();
               if (rsp_result_column !== want.col) begin
                  $error("result_column: expected %0d, actual %0d", want.col,
                         rsp_result_column);
                  failures++;
               end
               if (rsp_product_value !== want.value) begin
                  $error("product_value: expected %0d, actual %0d", want.value,
                         rsp_product_value);
                  failures++;
               end
               if (rsp_row_done !== want.done) begin
                  $error("row_done: expected %0d, actual %0d", want.done, rsp_row_done);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            tag = row_tags.pop_front();
            accumulate_request(req_operation, req_row_index, req_col_index,
                               req_element_value, tag);
         end
      end
   end

   task automatic send_request(input logic op, input logic [ROW_W-1:0] row,
                               input logic [ROW_W-1:0] col,
                               input logic signed [ELEM_W-1:0] value,
                               input bit typed, input logic signed [SUM_W-1:0] c_value);
      row_tag_type tag;
      int          gap;
      tag.typed   = typed;
      tag.c_value = c_value;
      row_tags.push_back(tag);
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_row_index     <= row;
      req_col_index     <= col;
      req_element_value <= value;
      do @(posedge clock); while (!req_ready);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic signed [ELEM_W-1:0] pick_element();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         3: return '1;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   initial begin
      int       order [N*N];
      int       i;
      int       k;
      int       n;
      int       swap;
      int       pick;
      int       issued;
      logic [ROW_W-1:0] r;
      logic [ROW_W-1:0] c;

      for (i = 0; i < N; i++)
         row_sums[i] = '0;
      for (i = 0; i < N * N; i++)
         b_image[i] = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < N_DIRECTED; i++)
         send_request(directed_table[i].op, directed_table[i].row, directed_table[i].col,
                      directed_table[i].value, directed_table[i].typed,
                      directed_table[i].c_value);

      for (i = 0; i < N * N; i++)
         order[i] = i;
      for (i = N * N - 1; i > 0; i--) begin
         k = $urandom_range(0, i);
         swap = order[i];
         order[i] = order[k];
         order[k] = swap;
      end
      for (i = 0; i < N * N; i++)
         send_request(OP_LOAD, ROW_W'(order[i] / N), ROW_W'(order[i] % N), pick_element(),
                      1'b0, '0);
      issued = N_DIRECTED + N * N;

      while (issued < ITEM_COUNT) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            for (k = 0; k < N; k++)
               send_request(OP_STREAM, ROW_W'(k), ROW_W'($urandom_range(0, 63)),
                            pick_element(), 1'b0, '0);
            issued += N;
         end else if (pick < 72) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
               r = ($urandom_range(0, 4) == 0) ? ROW_W'($urandom_range(0, 63))
                                               : ROW_W'($urandom_range(0, N-1));
               c = ($urandom_range(0, 4) == 0) ? ROW_W'($urandom_range(0, 63))
                                               : ROW_W'($urandom_range(0, N-1));
               send_request(OP_LOAD, r, c, pick_element(), 1'b0, '0);
            end
            issued += n;
         end else if (pick < 87) begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++)
               send_request(OP_STREAM, ROW_W'($urandom_range(0, N-1)),
                            ROW_W'($urandom_range(0, 63)), pick_element(), 1'b0, '0);
            issued += n;
         end else begin
            send_request(OP_STREAM, ROW_W'($urandom_range(N, 63)),
                         ROW_W'($urandom_range(0, 63)), pick_element(), 1'b0, '0);
            issued++;
         end
      end

      req_valid <= 1'b0;
      draining = 1'b1;
      while (c_expected.size() != 0)
         @(posedge clock);
      repeat (4 * ROW_LATENCY) @(posedge clock);

      if (c_expected.size() != 0) begin
         $error("missing results: %0d outstanding", c_expected.size());
         failures++;
      end

      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/mmrs_pkg.sv
rtl/mmrs_front.sv
rtl/mmrs_queue.sv
rtl/mmrs_back.sv
rtl/matrix_multiply_row_stream_core.sv
tb/tb.sv
